[sv/circular_deque_top_macros.svh]
// Assertion helpers for the deque top level.
`ifndef CIRCULAR_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_TOP_MACROS_SVH

// Same-cycle property, checked every clock outside reset.
`define CDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define CDQ_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

[sv/cdq_pkg.sv]
package cdq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET     = CAP_W'(DEPTH);
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);

  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [1:0] KIND_POP_BACK   = 2'd3;

  // Per-cycle command broadcast to every cell; at most one op bit is set.
  typedef struct packed {
    logic clear;
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctl_t;

endpackage

[sv/cdq_cell.sv]
module cdq_cell
  import cdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] push_value,
  input  logic              left_valid,
  input  logic [DATA_W-1:0] left_data,
  input  logic              right_valid,
  input  logic [DATA_W-1:0] right_data,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  output logic [DATA_W-1:0] tail_data_o
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic              is_tail;

  assign is_tail = valid_r & ~right_valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.push_front) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (ctl.pop_front) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (ctl.push_back && !valid_r && left_valid) begin
      // first free slot takes the new rear item
      valid_nxt = 1'b1;
      data_nxt  = push_value;
    end else if (ctl.pop_back && is_tail) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o     = valid_r;
  assign data_o      = data_r;
  assign tail_data_o = is_tail ? data_r : '0;

endmodule

[sv/circular_deque_top.sv]
// Double-ended queue of signed 32-bit values, built as a row of DEPTH cells.
// Input channel: in_valid/in_stall carry in_kind (push front, push back,
// pop front, pop back) and in_push_value. Result channel: out_valid/out_stall
// carry out_accepted, out_head_value, out_tail_value, out_now_empty and
// out_now_full, one result item per input item, in order.
// The result of an item is registered and valid the cycle after it is accepted.
// One item per cycle while in_stall is low; the whole cell row updates at once.
// A result waiting on a stalled receiver holds in_stall high, which freezes
// the queue so the result stays stable; once it is taken a new item is taken
// in the same cycle.
// Reset (rst_n low, synchronous) empties the queue and sets capacity to 16.
// Writing the capacity register over the APB port also empties the queue;
// capacity 0 acts as 1 and values above DEPTH act as DEPTH.
// Values read -1 when the queue is empty.
module circular_deque_top
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic signed [DATA_W-1:0] in_push_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_accepted,
  output logic signed [DATA_W-1:0] out_head_value,
  output logic signed [DATA_W-1:0] out_tail_value,
  output logic                     out_now_empty,
  output logic                     out_now_full,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

`include "circular_deque_top_macros.svh"

  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_eff;
  logic              out_valid_r, out_valid_nxt;
  logic              accepted_r;
  logic              in_fire, cfg_wr, is_full, is_empty;
  logic              is_push, op_ok;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic [DATA_W-1:0] cell_tail  [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DATA_W-1:0] tail_data;

  // --- configuration ------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_CAPACITY);
  assign prdata = (paddr == ADDR_CAPACITY) ? {{(32-CAP_W){1'b0}}, cap_r} : '0;
  assign cap_nxt = cfg_wr ? pwdata[CAP_W-1:0] : cap_r;

  // clamp capacity into 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if ({{(32-CAP_W){1'b0}}, cap_r} > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // --- handshake and occupancy -------------------------------------------
  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == cap_eff);
  assign is_push  = (in_kind == KIND_PUSH_FRONT) || (in_kind == KIND_PUSH_BACK);
  assign op_ok    = is_push ? ~is_full : ~is_empty;

  always_comb begin
    ctl            = '0;
    ctl.clear      = cfg_wr;
    if (in_fire && op_ok && !cfg_wr) begin
      case (in_kind)
        KIND_PUSH_FRONT: ctl.push_front = 1'b1;
        KIND_PUSH_BACK:  ctl.push_back  = 1'b1;
        KIND_POP_FRONT:  ctl.pop_front  = 1'b1;
        KIND_POP_BACK:   ctl.pop_back   = 1'b1;
        default:         ctl            = '0;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.push_front || ctl.push_back) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop_front || ctl.pop_back) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result stays up until taken; a new item replaces it in the same edge
  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted_r <= op_ok;
    end
  end

  // --- cell row: cell 0 is the front; a front push shifts items toward higher cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              lv, rv;
    logic [DATA_W-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = in_push_value;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    cdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_value (in_push_value),
      .left_valid (lv),
      .left_data  (ld),
      .right_valid(rv),
      .right_data (rd),
      .valid_o    (cell_valid[i]),
      .data_o     (cell_data[i]),
      .tail_data_o(cell_tail[i])
    );
  end

  // at most one cell flags itself as the rear; OR the gated values together
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | cell_tail[i];
    end
  end

  // --- outputs, read straight from the frozen state -------------------------
  assign out_valid      = out_valid_r;
  assign out_accepted   = accepted_r;
  assign out_now_empty  = is_empty;
  assign out_now_full   = is_full;
  assign out_head_value = is_empty ? '1 : cell_data[0];
  assign out_tail_value = is_empty ? '1 : tail_data;

  // --- checks --------------------------------------------------------------
  `CDQ_ASSERT(a_count_cap, count_r <= cap_eff, "occupancy above capacity")
  `CDQ_ASSERT(a_count_cells, $countones(cell_valid) == 32'(count_r),
    "occupancy count disagrees with cell row")
  `CDQ_ASSERT_NEXT(a_refused_hold, in_fire && !op_ok && !cfg_wr, count_r == $past(count_r),
    "refused operation changed occupancy")
  `CDQ_ASSERT_NEXT(a_stall_freeze, in_stall && !cfg_wr, count_r == $past(count_r),
    "queue changed while a result was stalled")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import cdq_pkg::*;

  // Expected results are built as each item enters and are compared as each result
  // leaves. The deque state kept here is a ring with both indices and the
  // capacity setting.
  class deque_scoreboard;
    typedef struct {
      logic              accepted;
      logic [DATA_W-1:0] head_value;
      logic [DATA_W-1:0] tail_value;
      logic              now_empty;
      logic              now_full;
    } deque_result_t;

    logic [DATA_W-1:0] ring [DEPTH];
    int unsigned       front_idx;
    int unsigned       rear_idx;
    bit                vacant;
    logic [CAP_W-1:0]  cap_reg;
    deque_result_t     expected_q[$];
    int                errors;
    int                checked;
    int                refused;
    int                full_hits;

    function new();
      foreach (ring[i]) ring[i] = '0;
      front_idx = 0;
      rear_idx  = 0;
      vacant    = 1'b1;
      cap_reg   = CAP_RESET;
    endfunction

    // A capacity write also empties the queue; stored values stay.
    function void write_capacity(logic [31:0] value);
      cap_reg   = value[CAP_W-1:0];
      front_idx = 0;
      rear_idx  = 0;
      vacant    = 1'b1;
    endfunction

    // 0 acts as 1, anything above the depth acts as the depth
    function int unsigned live_cap();
      int unsigned c;
      c = 32'(cap_reg);
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    function int unsigned step_up(int unsigned i, int unsigned c);
      return (i + 1 >= c) ? 0 : i + 1;
    endfunction

    function int unsigned step_down(int unsigned i, int unsigned c);
      return (i == 0 || i >= c) ? c - 1 : i - 1;
    endfunction

    function bit is_full(int unsigned c);
      return !vacant && step_up(rear_idx, c) == front_idx;
    endfunction

    function void note_item(logic [1:0] kind, logic [DATA_W-1:0] value);
      int unsigned   c;
      deque_result_t r;
      c = live_cap();
      r.accepted = 1'b0;
      if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
        if (!is_full(c)) begin
          r.accepted = 1'b1;
          if (vacant) begin
            front_idx = 0;
            rear_idx  = 0;
            vacant    = 1'b0;
            ring[0]   = value;
          end else if (kind == KIND_PUSH_FRONT) begin
            front_idx       = step_down(front_idx, c);
            ring[front_idx] = value;
          end else begin
            rear_idx       = step_up(rear_idx, c);
            ring[rear_idx] = value;
          end
        end
      end else if (!vacant) begin
        r.accepted = 1'b1;
        if (front_idx == rear_idx) begin
          front_idx = 0;
          rear_idx  = 0;
          vacant    = 1'b1;
        end else if (kind == KIND_POP_FRONT) begin
          front_idx = step_up(front_idx, c);
        end else begin
          rear_idx = step_down(rear_idx, c);
        end
      end
      r.head_value = vacant ? '1 : ring[front_idx];
      r.tail_value = vacant ? '1 : ring[rear_idx];
      r.now_empty  = vacant;
      r.now_full   = is_full(c);
      if (!r.accepted) refused++;
      if (r.now_full) full_hits++;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic acc, logic [DATA_W-1:0] hv, logic [DATA_W-1:0] tv,
                      logic emp, logic ful);
      deque_result_t r;
      if (expected_q.size() == 0) begin
        report("result arrived with nothing expected");
      end else begin
        r = expected_q.pop_front();
        checked++;
        if (acc !== r.accepted)
          report($sformatf("accepted %b, want %b", acc, r.accepted));
        if (hv !== r.head_value)
          report($sformatf("head_value %h, want %h", hv, r.head_value));
        if (tv !== r.tail_value)
          report($sformatf("tail_value %h, want %h", tv, r.tail_value));
        if (emp !== r.now_empty)
          report($sformatf("now_empty %b, want %b", emp, r.now_empty));
        if (ful !== r.now_full)
          report($sformatf("now_full %b, want %b", ful, r.now_full));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int RX_HOLD_CYCLES = 120;  // long receiver hold-off
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 93;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_kind = KIND_PUSH_BACK;
  logic signed [DATA_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b1;
  logic                     out_accepted;
  logic signed [DATA_W-1:0] out_head_value;
  logic signed [DATA_W-1:0] out_tail_value;
  logic                     out_now_empty;
  logic                     out_now_full;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = ADDR_CAPACITY;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  deque_scoreboard sb;
  bit              tx_busy;        // sender offers items back to back
  bit              rx_busy;        // receiver never stalls
  bit              hold_off_req;   // ask the receiver for one long hold-off
  int              cap_writes;

  circular_deque_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_head_value (out_head_value),
    .out_tail_value (out_tail_value),
    .out_now_empty  (out_now_empty),
    .out_now_full   (out_now_full),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Monitor: both handshakes are sampled at the edge. The result side is
  // checked first, before the item taken at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_accepted, out_head_value, out_tail_value,
                        out_now_empty, out_now_full);
      if (in_valid && !in_stall)
        sb.note_item(in_kind, in_push_value);
    end
  end

  // Per-item wait, drawn at random, or none in a busy stretch.
  function int draw_wait(bit busy);
    return busy ? 0 : $urandom_range(0, 17);
  endfunction

  // Pushes favor the signed extremes, 0 and -1 now and then.
  function logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: stalls a drawn number of cycles, then takes one result item.
  // A pending hold-off request is folded into the same stall so out_stall
  // gets a single assignment per edge.
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = draw_wait(rx_busy);
      if (hold_off_req) begin
        n += RX_HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offers one item and returns at the edge where it is taken. valid is only
  // lowered when a gap is drawn, so back-to-back items keep it high.
  task send_item(logic [1:0] kind, logic [DATA_W-1:0] value);
    int gap;
    gap = draw_wait(tx_busy);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender pause: nothing offered until every result item is back.
  // The first edge lets the monitor note the item taken at the last edge.
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);  // registered result, plus margin
  endtask

  // Setup then access cycle; the register takes the value at the access edge.
  task write_capacity(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_capacity(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_writes++;
  endtask

  initial begin
    logic [31:0] cap_plan [NUM_PHASES];
    logic [1:0]  kind;
    int          push_pct;
    int          guard;

    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset capacity: pops on empty are refused, a push into empty
    // lands at entry 0, extremes pass through, popping the last entry empties.
    send_item(KIND_POP_FRONT, rand_value());
    send_item(KIND_POP_BACK, rand_value());
    send_item(KIND_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(KIND_PUSH_FRONT, 32'h8000_0000);
    send_item(KIND_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(KIND_PUSH_FRONT, 32'h0000_0000);
    send_item(KIND_POP_FRONT, rand_value());
    send_item(KIND_POP_BACK, rand_value());
    send_item(KIND_POP_FRONT, rand_value());
    send_item(KIND_POP_BACK, rand_value());
    send_item(KIND_POP_BACK, rand_value());
    drain();

    // Capacity 1: one push fills it, both kinds of push are then refused.
    write_capacity(32'd1);
    send_item(KIND_PUSH_FRONT, 32'h5A5A_A5A5);
    send_item(KIND_PUSH_BACK, 32'h1234_5678);
    send_item(KIND_PUSH_FRONT, 32'hDEAD_BEEF);
    send_item(KIND_POP_BACK, rand_value());
    drain();

    // Capacity 2: front push from index 0 wraps to the top of the ring.
    write_capacity(32'd2);
    send_item(KIND_PUSH_BACK, rand_value());
    send_item(KIND_PUSH_FRONT, rand_value());
    send_item(KIND_PUSH_BACK, rand_value());
    send_item(KIND_POP_FRONT, rand_value());
    send_item(KIND_PUSH_BACK, rand_value());
    send_item(KIND_POP_BACK, rand_value());
    send_item(KIND_POP_BACK, rand_value());
    drain();

    // Random phases. Capacity 0 and values above the depth are clamped;
    // upper data bits are outside the register and must be ignored.
    cap_plan = '{32'd16, 32'd1, 32'd0, 32'd31, 32'd2, 32'd17,
                 32'd7, 32'd0, 32'd16, 32'd0};
    cap_plan[7] = $urandom_range(1, 16);
    cap_plan[9] = {27'($urandom_range(0, 32'h07FF_FFFF)), 5'($urandom_range(0, 31))};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(cap_plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // New traffic shape every 20 items: fill-heavy, drain-heavy or mixed.
        if (i % 20 == 0) begin
          case ($urandom_range(0, 2))
            0:       push_pct = 80;
            1:       push_pct = 25;
            default: push_pct = 50;
          endcase
          tx_busy = ($urandom_range(0, 2) == 0);
          rx_busy = ($urandom_range(0, 2) == 0);
        end
        // Phase 3: receiver holds off long while the sender keeps sending items
        // back to back, so the result side backs up into in_stall.
        if (p == 3 && i == 30) begin
          tx_busy      = 1'b1;
          hold_off_req = 1'b1;
        end
        if ($urandom_range(0, 99) < push_pct)
          kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else
          kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        send_item(kind, rand_value());
      end
      drain();
    end

    in_valid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);

    $display("Covered %0d items across %0d capacity writes (0, 1, 2, 16 and above depth).",
             sb.checked, cap_writes);
    $display("%0d operations refused on full or empty; full flag seen %0d times.",
             sb.refused, sb.full_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[circular_deque_top.f]
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_cell.sv
sv/circular_deque_top.sv
verif/tb_top.sv
